>>> hdl/assert_macros.svh
// Assertion macros used by the RTL. They expand to nothing in synthesis.
// The module that uses them must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");
`define CHS_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define CHS_ASSERT(lbl, cond)
`define CHS_ASSERT_IMP(lbl, pre, post)
`endif
`endif

>>> hdl/chs_pkg.sv
package chs_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int NODE_CAPACITY_DEF = 4096;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int HASH_SHIFT        = 4;
    localparam int FIELD_W           = 13;
    localparam logic [FIELD_W-1:0] SEG_RESET = 13'd256;

    typedef enum logic [2:0] {
        CMD_ADD_CHK   = 3'd0,
        CMD_ADD_UNCHK = 3'd1,
        CMD_DELETE    = 3'd2,
        CMD_QUERY     = 3'd3,
        CMD_CLEAR     = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CLR,
        S_BKT,
        S_HEAD,
        S_NODE,
        S_INS,
        S_FIN
    } t_state;

endpackage

>>> hdl/chs_ram.sv
module chs_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/chs_div.sv
module chs_div #(
    parameter int DW = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DW-1:0]                i_dividend,
    input  logic [chs_pkg::FIELD_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [DW-1:0]                o_quot,
    output logic [chs_pkg::FIELD_W-1:0]  o_rem
);
    import chs_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [DW-1:0]      r_q;
    logic [FIELD_W-1:0] r_r;
    logic [FIELD_W-1:0] r_d;
    logic [FIELD_W:0]   trial;
    logic               take;

    // One quotient bit per cycle, restoring.
    assign trial = {r_r, r_q[DW-1]};
    assign take  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DW-2:0], take};
            r_r <= take ? FIELD_W'(trial - {1'b0, r_d}) : trial[FIELD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

>>> hdl/chained_hash_set_engine.sv
// A command runs through accept, bucket read, head, a walk over the chain nodes visited, an insert
// step for adds, and then the result is registered.
// Throughput: one command at a time; the chain walk through node memory sets the rate.
// Clear sweeps every bucket head to zero; a segment size write costs a divide of the nodes taken
// by the segment size before the next command is taken.
// Reset (synchronous, active low) starts a sweep zeroing all TABLE_ENTRIES bucket heads.
`include "assert_macros.svh"

module chained_hash_set_engine #(
    parameter int TABLE_ENTRIES = chs_pkg::TABLE_ENTRIES_DEF,
    parameter int NODE_CAPACITY = chs_pkg::NODE_CAPACITY_DEF,
    parameter int KEY_WIDTH     = chs_pkg::KEY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [2:0] command, [34:3] key, [39:35] zero
    input  logic [39:0]                 i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [0] found, [1] began_new_segment, [2] store_full, [3] ever_overflowed,
    // [16:4] live_count, [29:17] segments_used, [31:30] zero
    output logic [31:0]                 o_m_tdata,
    input  logic                        i_cfg_we,
    input  logic [chs_pkg::FIELD_W-1:0] i_cfg_wdata
);
    import chs_pkg::*;

    // Node references are node number plus one, zero meaning none.
    localparam int NREF_W = $clog2(NODE_CAPACITY + 1);
    localparam int NODE_AW = $clog2(NODE_CAPACITY);
    localparam int TBL_W = $clog2(TABLE_ENTRIES);
    localparam int NODE_W = KEY_WIDTH + NREF_W;

    t_state              r_state, n_state;
    logic [2:0]          r_cmd, n_cmd;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [NREF_W-1:0]   r_head, n_head;
    logic [NREF_W-1:0]   r_ref, n_ref;
    logic                r_found, n_found;
    logic                r_began, n_began;
    logic                r_full, n_full;
    logic [NREF_W-1:0]   r_taken, n_taken;
    logic [NREF_W-1:0]   r_live, n_live;
    logic [FIELD_W-1:0]  r_off, n_off;
    logic [NREF_W-1:0]   r_used, n_used;
    logic                r_ovf, n_ovf;
    logic [FIELD_W-1:0]  r_seg;
    logic                r_dirty;
    logic [TBL_W-1:0]    r_clr_addr, n_clr_addr;
    logic                r_clr_cmd, n_clr_cmd;
    logic                r_ovalid, n_ovalid;
    logic [31:0]         r_odata, n_odata;

    logic                in_acc;
    logic [KEY_WIDTH-1:0] in_key;
    logic [FIELD_W-1:0]  seg_eff;
    logic [63:0]         key_shift;
    logic [TBL_W-1:0]    bucket;

    logic                b_we, b_re;
    logic [TBL_W-1:0]    b_waddr;
    logic [NREF_W-1:0]   b_wdata, b_rdata;
    logic                nd_we, nd_re;
    logic [NODE_AW-1:0]  nd_waddr, nd_raddr;
    logic [NODE_W-1:0]   nd_wdata, nd_rdata;
    logic [KEY_WIDTH-1:0] nd_key;
    logic [NREF_W-1:0]   nd_link;
    logic [NREF_W-1:0]   head_m1, link_m1, ref_m1;
    logic [FIELD_W-1:0]  off_inc;
    logic                ins_new_seg;

    logic                div_start, div_done;
    logic [NREF_W-1:0]   div_quot;
    logic [FIELD_W-1:0]  div_rem;

    assign in_acc = i_s_tvalid && o_s_tready;
    // Commands are only taken once any pending segment recompute has finished.
    assign o_s_tready = (r_state == S_IDLE) && !r_dirty;
    assign in_key = KEY_WIDTH'(i_s_tdata[34:3]);

    // A segment size of zero behaves as one.
    assign seg_eff = (r_seg == '0) ? FIELD_W'(1) : r_seg;

    assign key_shift = 64'(r_key) >> HASH_SHIFT;
    assign bucket = key_shift[TBL_W-1:0];

    assign nd_key  = nd_rdata[KEY_WIDTH-1:0];
    assign nd_link = nd_rdata[KEY_WIDTH +: NREF_W];
    assign head_m1 = b_rdata - 1'b1;
    assign link_m1 = nd_link - 1'b1;
    assign ref_m1  = r_ref - 1'b1;
    assign off_inc = r_off + 1'b1;
    // Taking the first node of any segment but the first is an overflow.
    assign ins_new_seg = (r_taken != '0) && (r_off == '0);

    chs_ram #(.WIDTH(NREF_W), .DEPTH(TABLE_ENTRIES)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (bucket),
        .o_rdata (b_rdata)
    );

    // Each node word holds its link above its key.
    chs_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAPACITY)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_re    (nd_re),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    // The segment count and the offset within the current segment are kept
    // incrementally; after a change of segment size they are recomputed from
    // the number of nodes taken by this serial divider.
    chs_div #(.DW(NREF_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_taken),
        .i_divisor  (seg_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_cmd  <= 1'b0;
            r_taken    <= '0;
            r_live     <= '0;
            r_off      <= '0;
            r_used     <= NREF_W'(1);
            r_ovf      <= 1'b0;
            r_seg      <= SEG_RESET;
            r_dirty    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_cmd  <= n_clr_cmd;
            r_taken    <= n_taken;
            r_live     <= n_live;
            r_off      <= n_off;
            r_used     <= n_used;
            r_ovf      <= n_ovf;
            r_ovalid   <= n_ovalid;
            if (i_cfg_we) begin
                r_seg <= i_cfg_wdata;
            end
            // A write that lands as the divide starts keeps the flag set, so
            // the divide simply runs again with the new size.
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
            end else if (div_start) begin
                r_dirty <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_head  <= n_head;
        r_ref   <= n_ref;
        r_found <= n_found;
        r_began <= n_began;
        r_full  <= n_full;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_head     = r_head;
        n_ref      = r_ref;
        n_found    = r_found;
        n_began    = r_began;
        n_full     = r_full;
        n_taken    = r_taken;
        n_live     = r_live;
        n_off      = r_off;
        n_used     = r_used;
        n_ovf      = r_ovf;
        n_clr_addr = r_clr_addr;
        n_clr_cmd  = r_clr_cmd;
        n_odata    = r_odata;
        n_ovalid   = r_ovalid && !i_m_tready;
        b_we       = 1'b0;
        b_re       = 1'b0;
        b_waddr    = bucket;
        b_wdata    = '0;
        nd_we      = 1'b0;
        nd_re      = 1'b0;
        nd_waddr   = ref_m1[NODE_AW-1:0];
        nd_wdata   = {nd_link, {KEY_WIDTH{1'b0}}};
        nd_raddr   = link_m1[NODE_AW-1:0];
        div_start  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (r_dirty) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else if (in_acc) begin
                    n_cmd   = i_s_tdata[2:0];
                    n_key   = in_key;
                    n_found = 1'b0;
                    n_began = 1'b0;
                    n_full  = 1'b0;
                    if (i_s_tdata[2:0] == CMD_CLEAR) begin
                        n_state    = S_CLR;
                        n_clr_addr = '0;
                        n_clr_cmd  = 1'b1;
                    end else if (i_s_tdata[2:0] > CMD_CLEAR || in_key == '0) begin
                        // Unknown commands and the reserved zero key do nothing.
                        n_state = S_FIN;
                    end else begin
                        n_state = S_BKT;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_IDLE;
                    if (r_taken == '0) begin
                        n_off  = '0;
                        n_used = NREF_W'(1);
                    end else begin
                        n_off  = div_rem;
                        n_used = (div_rem == '0) ? div_quot : div_quot + 1'b1;
                    end
                end
            end
            S_CLR: begin
                b_we    = 1'b1;
                b_waddr = r_clr_addr;
                if (r_clr_addr == TBL_W'(TABLE_ENTRIES - 1)) begin
                    n_taken = '0;
                    n_live  = '0;
                    n_off   = '0;
                    n_used  = NREF_W'(1);
                    n_ovf   = 1'b0;
                    n_state = r_clr_cmd ? S_FIN : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_BKT: begin
                b_re    = 1'b1;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_head = b_rdata;
                if (r_cmd == CMD_ADD_UNCHK) begin
                    n_state = S_INS;
                end else if (b_rdata == '0) begin
                    n_state = (r_cmd == CMD_ADD_CHK) ? S_INS : S_FIN;
                end else begin
                    nd_re    = 1'b1;
                    nd_raddr = head_m1[NODE_AW-1:0];
                    n_ref    = b_rdata;
                    n_state  = S_NODE;
                end
            end
            S_NODE: begin
                // Tombstones hold key zero and never match a live key.
                if (nd_key == r_key) begin
                    n_found = 1'b1;
                    n_state = S_FIN;
                    if (r_cmd == CMD_DELETE) begin
                        nd_we = 1'b1;
                        if (r_live != '0) begin
                            n_live = r_live - 1'b1;
                        end
                    end
                end else if (nd_link == '0) begin
                    n_state = (r_cmd == CMD_ADD_CHK) ? S_INS : S_FIN;
                end else begin
                    nd_re = 1'b1;
                    n_ref = nd_link;
                end
            end
            S_INS: begin
                n_state = S_FIN;
                if (r_taken >= NREF_W'(NODE_CAPACITY)) begin
                    n_full = 1'b1;
                end else begin
                    n_began  = ins_new_seg;
                    n_ovf    = r_ovf || ins_new_seg;
                    nd_we    = 1'b1;
                    nd_waddr = r_taken[NODE_AW-1:0];
                    nd_wdata = {r_head, r_key};
                    b_we     = 1'b1;
                    b_wdata  = r_taken + 1'b1;
                    n_taken  = r_taken + 1'b1;
                    n_live   = r_live + 1'b1;
                    n_off    = (off_inc == seg_eff) ? '0 : off_inc;
                    n_used   = ins_new_seg ? r_used + 1'b1 : r_used;
                end
            end
            S_FIN: begin
                // Wait here only while an earlier result is still unclaimed.
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {2'b00, FIELD_W'(r_used), FIELD_W'(r_live),
                                r_ovf, r_full, r_began, r_found};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    `CHS_ASSERT(a_live_le_taken, r_live <= r_taken)
    `CHS_ASSERT(a_used_nonzero, r_used != '0)
    `CHS_ASSERT(a_off_in_seg, r_state != S_IDLE || r_dirty || r_off < seg_eff)
    `CHS_ASSERT_IMP(a_clear_sweeps, in_acc && i_s_tdata[2:0] == CMD_CLEAR, r_state == S_CLR)
    `CHS_ASSERT_IMP(a_insert_takes, r_state == S_INS && r_taken < NREF_W'(NODE_CAPACITY),
        r_taken == $past(r_taken) + 1'b1)

endmodule
